// File: sv/ncs_pkg.sv
// package for the nearest palette color search: constants, types and state codes
`timescale 1ns / 1ps
package ncs_pkg;

  localparam int PaletteDepth = 256;
  localparam int IdxW         = $clog2(PaletteDepth);
  localparam int CntW         = $clog2(PaletteDepth + 1);
  localparam int CfgW         = 9;
  localparam int CompW        = 8;
  localparam int EntryW       = 3 * CompW;
  localparam int DistW        = 18;
  localparam int SlotW        = 8;

  localparam logic [CfgW-1:0] CountReset = CfgW'(256);

  localparam logic ActWrite = 1'b0;
  localparam logic ActQuery = 1'b1;

  typedef enum logic [1:0] {
    ScanIdle,
    ScanRun,
    ScanDrain,
    ScanHold
  } scan_state_e;

  // tag that travels with each palette read through the pipe
  typedef struct packed {
    logic            vld;
    logic [IdxW-1:0] idx;
    logic            last;
  } ncs_tag_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
  } ncs_rd_req_t;

  typedef struct packed {
    logic            vld;
    logic [IdxW-1:0] idx;
  } ncs_res_t;

endpackage

// File: sv/nearest_palette_color_search.sv
// top level of the nearest palette color search: stream ports, palette ram, scan, result register
// a write item does not stall the input and the next item can follow right behind it
// a query reads one entry per cycle; its result passes the palette read, distance register and
// best-index register into the output register, a zero entry_count gives index 0 with no read
// the input stays stalled until the result enters the output register, longer while it is full
// reset (rst_ni low, async) clears control and sets entry_count to 256; palette is not cleared
`timescale 1ns / 1ps
module nearest_palette_color_search (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // item input
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [31:0]              s_axis_tdata,   // entry_index, red, green, blue
  input  logic                     s_axis_tuser,   // action
  // result output
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [7:0]               m_axis_tdata,   // nearest index
  // entry_count register
  input  logic                     cfg_we_i,
  input  logic [ncs_pkg::CfgW-1:0] cfg_wdata_i
);
  import ncs_pkg::*;

  logic              in_acc;
  logic              wr_item;
  logic              query_item;
  logic [SlotW-1:0]  slot;
  logic [EntryW-1:0] color;
  logic              slot_ok;

  logic [CfgW-1:0]   entry_count_q;
  logic [CntW-1:0]   count_sat;

  ncs_rd_req_t       rd_req;
  logic [EntryW-1:0] rd_data;
  ncs_res_t          res;
  logic              res_rdy;
  logic              scan_busy;

  logic              out_vld_q;
  logic [IdxW-1:0]   out_idx_q;

  // item decode
  assign slot       = s_axis_tdata[SlotW-1:0];
  // red high, blue low
  assign color      = {s_axis_tdata[SlotW +: CompW], s_axis_tdata[SlotW+CompW +: CompW],
                       s_axis_tdata[SlotW+2*CompW +: CompW]};
  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign wr_item    = in_acc && (s_axis_tuser == ActWrite);
  assign query_item = in_acc && (s_axis_tuser == ActQuery);

  // slots past the palette depth are dropped
  assign slot_ok = ({1'b0, slot} < (SlotW+1)'(PaletteDepth));

  // take a new item only while no scan is in flight
  assign s_axis_tready = !scan_busy;

  // entry_count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= CountReset;
    end else if (cfg_we_i) begin
      entry_count_q <= cfg_wdata_i;
    end
  end

  // counts above the depth search the whole palette
  assign count_sat = (entry_count_q > CfgW'(PaletteDepth)) ? CntW'(PaletteDepth)
                                                           : CntW'(entry_count_q);

  // palette memory, written by write items, read by the scan
  ncs_ram #(
    .Width (EntryW),
    .Depth (PaletteDepth)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (wr_item && slot_ok),
    .waddr_i (slot[IdxW-1:0]),
    .wdata_i (color),
    .re_i    (rd_req.en),
    .raddr_i (rd_req.addr),
    .rdata_o (rd_data)
  );

  ncs_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (query_item),
    .target_i  (color),
    .count_i   (count_sat),
    .rd_req_o  (rd_req),
    .rd_data_i (rd_data),
    .res_o     (res),
    .res_rdy_i (res_rdy),
    .busy_o    (scan_busy)
  );

  // output register, refilled as soon as the previous result is taken
  assign res_rdy = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_rdy) begin
      out_vld_q <= res.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_rdy && res.vld) begin
      out_idx_q <= res.idx;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = 8'(out_idx_q);

endmodule

// File: sv/ncs_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module ncs_ram #(
  parameter int Width = 24,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: sv/ncs_dist.sv
// squared euclidean distance stage between a palette entry and the target
`timescale 1ns / 1ps
module ncs_dist (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ncs_pkg::ncs_tag_t          tag_i,
  input  logic [ncs_pkg::EntryW-1:0] entry_i,
  input  logic [ncs_pkg::EntryW-1:0] target_i,
  output ncs_pkg::ncs_tag_t          tag_o,
  output logic [ncs_pkg::DistW-1:0]  dist_o
);
  import ncs_pkg::*;

  logic [CompW-1:0]   d_r, d_g, d_b;
  logic [2*CompW-1:0] sq_r, sq_g, sq_b;
  logic [DistW-1:0]   dist_d, dist_q;
  ncs_tag_t           tag_q;

  function automatic logic [CompW-1:0] abs_diff(logic [CompW-1:0] a, logic [CompW-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    d_r    = abs_diff(entry_i[3*CompW-1:2*CompW], target_i[3*CompW-1:2*CompW]);
    d_g    = abs_diff(entry_i[2*CompW-1:CompW], target_i[2*CompW-1:CompW]);
    d_b    = abs_diff(entry_i[CompW-1:0], target_i[CompW-1:0]);
    sq_r   = (2*CompW)'(d_r) * (2*CompW)'(d_r);
    sq_g   = (2*CompW)'(d_g) * (2*CompW)'(d_g);
    sq_b   = (2*CompW)'(d_b) * (2*CompW)'(d_b);
    dist_d = DistW'(sq_r) + DistW'(sq_g) + DistW'(sq_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
  end

  assign tag_o  = tag_q;
  assign dist_o = dist_q;

endmodule

// File: sv/ncs_scan.sv
// scan sequencer: walks the palette memory and keeps the nearest entry so far
`timescale 1ns / 1ps
module ncs_scan (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ncs_pkg::EntryW-1:0] target_i,
  input  logic [ncs_pkg::CntW-1:0]   count_i,
  output ncs_pkg::ncs_rd_req_t       rd_req_o,
  input  logic [ncs_pkg::EntryW-1:0] rd_data_i,
  output ncs_pkg::ncs_res_t          res_o,
  input  logic                       res_rdy_i,
  output logic                       busy_o
);
  import ncs_pkg::*;

  scan_state_e       state_q, state_d;
  logic [IdxW-1:0]   addr_q, addr_d;
  logic [IdxW-1:0]   last_q, last_d;
  logic [EntryW-1:0] target_q;
  ncs_tag_t          rd_tag_q, rd_tag_d;
  ncs_tag_t          dist_tag;
  logic [DistW-1:0]  sq_sum;
  logic [IdxW-1:0]   best_idx_q, best_idx_d;
  logic [DistW-1:0]  min_sq_q, min_sq_d;
  logic              have_q, have_d;
  logic [IdxW-1:0]   count_m1;

  // a full palette count wraps to the top index
  assign count_m1 = count_i[IdxW-1:0] - IdxW'(1);

  ncs_dist u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tag_i    (rd_tag_q),
    .entry_i  (rd_data_i),
    .target_i (target_q),
    .tag_o    (dist_tag),
    .dist_o   (sq_sum)
  );

  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    last_d     = last_q;
    rd_tag_d   = '0;
    rd_req_o   = '0;
    res_o      = '0;
    best_idx_d = best_idx_q;
    min_sq_d   = min_sq_q;
    have_d     = have_q;

    // compare stage, first entry always wins, ties keep the lower index
    if (dist_tag.vld && (!have_q || (sq_sum < min_sq_q))) begin
      best_idx_d = dist_tag.idx;
      min_sq_d   = sq_sum;
      have_d     = 1'b1;
    end

    unique case (state_q)
      ScanIdle: begin
        if (start_i) begin
          addr_d     = '0;
          last_d     = count_m1;
          have_d     = 1'b0;
          best_idx_d = '0;
          // empty palette reports index zero straight away
          state_d    = (count_i == '0) ? ScanHold : ScanRun;
        end
      end
      ScanRun: begin
        rd_req_o.en   = 1'b1;
        rd_req_o.addr = addr_q;
        rd_tag_d.vld  = 1'b1;
        rd_tag_d.idx  = addr_q;
        rd_tag_d.last = (addr_q == last_q);
        if (addr_q == last_q) begin
          state_d = ScanDrain;
        end else begin
          addr_d = addr_q + IdxW'(1);
        end
      end
      ScanDrain: begin
        if (dist_tag.vld && dist_tag.last) begin
          state_d = ScanHold;
        end
      end
      ScanHold: begin
        res_o.vld = 1'b1;
        res_o.idx = best_idx_q;
        if (res_rdy_i) begin
          state_d = ScanIdle;
        end
      end
      default: state_d = ScanIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ScanIdle;
      rd_tag_q <= '0;
      have_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_tag_q <= rd_tag_d;
      have_q   <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    last_q     <= last_d;
    best_idx_q <= best_idx_d;
    min_sq_q   <= min_sq_d;
    if (start_i && (state_q == ScanIdle)) begin
      target_q <= target_i;
    end
  end

  assign busy_o = (state_q != ScanIdle);

endmodule
